FILE: rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordW    = 16;
  localparam int DiffW     = 17;
  localparam int ProdW     = 34;
  localparam int KW        = 35;
  localparam int MagW      = 34;
  localparam int PosW      = 6;
  localparam int GW        = 30;
  localparam int SqW       = 60;
  localparam int RadW      = 62;
  localparam int RootW     = 31;
  localparam int RemW      = 32;
  localparam int QuoW      = 15;
  localparam int OutW      = 16;
  localparam int Lanes     = 3;
  localparam int SqrtSteps = 31;
  localparam int DivSteps  = 15;

  // target leading-one position of the scaled largest component
  localparam logic [PosW-1:0] NormPos = 6'd29;
  localparam logic signed [OutW-1:0] UnitQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic signed [OutW-1:0] nx;
    logic signed [OutW-1:0] ny;
    logic signed [OutW-1:0] nz;
    logic                   degenerate;
  } norm_t;

  typedef struct packed {
    logic [Lanes-1:0] neg;
    logic             deg;
  } sgn_t;

  typedef struct packed {
    logic [Lanes-1:0][GW-1:0] g;
    sgn_t                     sg;
  } side_t;

endpackage

FILE: rtl/triangle_face_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal
// Flat-shaded unit face normal (Q1.14) of one Q7.8 triangle per item.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: in_valid_i / in_stall_o carry one triangle (three vertices)
//   per item; an item is taken when valid is high and stall is low.
//   out channel: out_valid_o / out_stall_i carry the normal and a degenerate
//   flag; a zero cross product gives a zero normal with degenerate set.
//   An item passes 56 register stages between the accepting edge and the
//   output register, which drives out_valid_o and out_data_o.
//   The stages are 8 of edge, cross product, scaling and squaring, 31 of
//   square root (one root bit per stage), 16 of division (prep plus one
//   quotient bit per stage) and the output register.
//   Throughput is one item per cycle unless stalled; all stages move together.
//   When the receiver stalls a valid result, every stage holds and
//   in_stall_o rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tfn_pkg::tri_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfn_pkg::norm_t out_data_o
);
  import tfn_pkg::*;

  function automatic logic [PosW-1:0] lead_one(input logic [MagW-1:0] m);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 0; i < MagW; i++) begin
      if (m[i]) p = PosW'(i);
    end
    return p;
  endfunction

  logic en;
  logic out_valid_q;
  norm_t out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // valid bits of the front stages
  logic [7:0] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[6:0], in_valid_i};
    end
  end

  // stage 1: edge vectors
  logic signed [DiffW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  // stage 2: products
  logic signed [ProdW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  // stage 3: magnitudes and signs
  logic [Lanes-1:0][MagW-1:0] mag3_q;
  logic [Lanes-1:0]           neg3_q;
  // stage 4: largest magnitude
  logic [Lanes-1:0][MagW-1:0] mag4_q;
  logic [Lanes-1:0]           neg4_q;
  logic [MagW-1:0]            max4_q;
  // stage 5: leading-one position
  logic [Lanes-1:0][MagW-1:0] mag5_q;
  logic [PosW-1:0]            pos5_q;
  sgn_t                       sg5_q;
  // stage 6: scaled magnitudes
  side_t                      side6_q;
  // stage 7: squares
  logic [Lanes-1:0][SqW-1:0]  sq7_q;
  side_t                      side7_q;
  // stage 8: sum of squares
  logic [RadW-1:0]            rad8_q;
  side_t                      side8_q;

  logic signed [KW-1:0]       kx, ky, kz;
  logic [Lanes-1:0][KW-1:0]   kv;
  logic [MagW-1:0]            max_d;
  logic [Lanes-1:0][GW-1:0]   g_d;
  logic [MagW-1:0]            shr, shl;

  always_comb begin
    kx = {pa_q[ProdW-1], pa_q} - {pb_q[ProdW-1], pb_q};
    ky = {pc_q[ProdW-1], pc_q} - {pd_q[ProdW-1], pd_q};
    kz = {pe_q[ProdW-1], pe_q} - {pf_q[ProdW-1], pf_q};
    kv[0] = kx[KW-1] ? -kx : kx;
    kv[1] = ky[KW-1] ? -ky : ky;
    kv[2] = kz[KW-1] ? -kz : kz;

    max_d = mag3_q[0];
    if (mag3_q[1] > max_d) max_d = mag3_q[1];
    if (mag3_q[2] > max_d) max_d = mag3_q[2];

    shr = '0;
    shl = '0;
    for (int l = 0; l < Lanes; l++) begin
      shr = mag5_q[l] >> (pos5_q - NormPos);
      shl = mag5_q[l] << (NormPos - pos5_q);
      g_d[l] = (pos5_q > NormPos) ? shr[GW-1:0] : shl[GW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= {in_data_i.bx[CoordW-1], in_data_i.bx} - {in_data_i.ax[CoordW-1], in_data_i.ax};
      uy_q <= {in_data_i.by[CoordW-1], in_data_i.by} - {in_data_i.ay[CoordW-1], in_data_i.ay};
      uz_q <= {in_data_i.bz[CoordW-1], in_data_i.bz} - {in_data_i.az[CoordW-1], in_data_i.az};
      wx_q <= {in_data_i.cx[CoordW-1], in_data_i.cx} - {in_data_i.ax[CoordW-1], in_data_i.ax};
      wy_q <= {in_data_i.cy[CoordW-1], in_data_i.cy} - {in_data_i.ay[CoordW-1], in_data_i.ay};
      wz_q <= {in_data_i.cz[CoordW-1], in_data_i.cz} - {in_data_i.az[CoordW-1], in_data_i.az};

      pa_q <= uy_q * wz_q;
      pb_q <= uz_q * wy_q;
      pc_q <= uz_q * wx_q;
      pd_q <= ux_q * wz_q;
      pe_q <= ux_q * wy_q;
      pf_q <= uy_q * wx_q;

      for (int l = 0; l < Lanes; l++) begin
        mag3_q[l] <= kv[l][MagW-1:0];
      end
      neg3_q <= {kz[KW-1], ky[KW-1], kx[KW-1]};

      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      max4_q <= max_d;

      mag5_q     <= mag4_q;
      pos5_q     <= lead_one(max4_q);
      sg5_q.neg  <= neg4_q;
      sg5_q.deg  <= (max4_q == '0);

      side6_q.g  <= g_d;
      side6_q.sg <= sg5_q;

      for (int l = 0; l < Lanes; l++) begin
        sq7_q[l] <= side6_q.g[l] * side6_q.g[l];
      end
      side7_q <= side6_q;

      rad8_q  <= {2'b00, sq7_q[0]} + {2'b00, sq7_q[1]} + {2'b00, sq7_q[2]};
      side8_q <= side7_q;
    end
  end

  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  side_t            sq_side;

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[7]),
    .rad_i   (rad8_q),
    .side_i  (side8_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  logic                       dv_valid;
  logic [Lanes-1:0][QuoW-1:0] dv_quo;
  sgn_t                       dv_sgn;

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sgn_o   (dv_sgn)
  );

  norm_t                      out_d;
  logic [Lanes-1:0][OutW-1:0] n_d;
  logic [OutW-1:0]            qext;

  always_comb begin
    qext = '0;
    for (int l = 0; l < Lanes; l++) begin
      qext   = {1'b0, dv_quo[l]};
      n_d[l] = dv_sgn.deg ? '0 : (dv_sgn.neg[l] ? -qext : qext);
    end
    out_d.nx         = n_d[0];
    out_d.ny         = n_d[1];
    out_d.nz         = n_d[2];
    out_d.degenerate = dv_sgn.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.nx == '0 && out_data_o.ny == '0 && out_data_o.nz == '0)
    else $error("degenerate item with nonzero normal");

  a_nondeg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate |->
      out_data_o.nx != '0 || out_data_o.ny != '0 || out_data_o.nz != '0)
    else $error("regular item with zero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.nx <= UnitQ14 && out_data_o.nx >= -UnitQ14 &&
      out_data_o.ny <= UnitQ14 && out_data_o.ny >= -UnitQ14 &&
      out_data_o.nz <= UnitQ14 && out_data_o.nz >= -UnitQ14)
    else $error("normal component out of unit range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without an output stall");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(fv_q) && $stable(rad8_q))
    else $error("front pipeline moved while stalled");
`endif

endmodule

FILE: rtl/tfn_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tfn_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tfn_pkg::RadW-1:0]  rad_i,
  input  tfn_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [tfn_pkg::RootW-1:0] root_o,
  output tfn_pkg::side_t            side_o
);
  import tfn_pkg::*;

  logic [SqrtSteps-1:0] valid_q;
  logic [RadW-1:0]      rad_q  [SqrtSteps];
  logic [RootW-1:0]     root_q [SqrtSteps];
  logic [RemW-1:0]      rem_q  [SqrtSteps];
  side_t                side_q [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    logic             v_in;
    logic [RadW-1:0]  rad_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in;
    side_t            side_in;
    logic [RemW+1:0]  remx;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic [RootW-1:0] root_d;
    logic [RemW-1:0]  rem_d;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      // bring down the next two radicand bits, try root*4+1
      remx  = {rem_in, rad_in[RadW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = remx - trial;
      if (remx >= trial) begin
        rem_d  = diff[RemW-1:0];
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = remx[RemW-1:0];
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= {rad_in[RadW-3:0], 2'b00};
        root_q[j] <= root_d;
        rem_q[j]  <= rem_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1];
  assign side_o  = side_q[SqrtSteps-1];

endmodule

FILE: rtl/tfn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined restoring divider: (32768*g + r) / (2*r), rounded.
// ----------------------------------------------------------------------------
module tfn_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [tfn_pkg::RootW-1:0]                  root_i,
  input  tfn_pkg::side_t                             side_i,
  output logic                                       valid_o,
  output logic [tfn_pkg::Lanes-1:0][tfn_pkg::QuoW-1:0] quo_o,
  output tfn_pkg::sgn_t                              sgn_o
);
  import tfn_pkg::*;

  // prep stage: numerator high part, divisor, low numerator bits
  logic                         pvalid_q;
  logic [Lanes-1:0][RemW-1:0]   prem_q;
  logic [RemW-1:0]              pdvs_q;
  logic [QuoW-1:0]              plow_q;
  sgn_t                         psgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (en_i) begin
      pvalid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < Lanes; l++) begin
        prem_q[l] <= {2'b00, side_i.g[l]} + {16'd0, root_i[RootW-1:QuoW]};
      end
      pdvs_q <= {root_i, 1'b0};
      plow_q <= root_i[QuoW-1:0];
      psgn_q <= side_i.sg;
    end
  end

  logic [DivSteps-1:0]        valid_q;
  logic [Lanes-1:0][RemW-1:0] rem_q [DivSteps];
  logic [Lanes-1:0][QuoW-1:0] quo_q [DivSteps];
  logic [RemW-1:0]            dvs_q [DivSteps];
  logic [QuoW-1:0]            low_q [DivSteps];
  sgn_t                       sgn_q [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic                       v_in;
    logic [Lanes-1:0][RemW-1:0] rem_in;
    logic [Lanes-1:0][QuoW-1:0] quo_in;
    logic [RemW-1:0]            dvs_in;
    logic [QuoW-1:0]            low_in;
    sgn_t                       sgn_in;
    logic [Lanes-1:0][RemW-1:0] rem_d;
    logic [Lanes-1:0][QuoW-1:0] quo_d;
    logic [RemW:0]              remx;
    logic [RemW:0]              diff;

    if (j == 0) begin : g_first
      assign v_in   = pvalid_q;
      assign rem_in = prem_q;
      assign quo_in = '0;
      assign dvs_in = pdvs_q;
      assign low_in = plow_q;
      assign sgn_in = psgn_q;
    end else begin : g_next
      assign v_in   = valid_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dvs_in = dvs_q[j-1];
      assign low_in = low_q[j-1];
      assign sgn_in = sgn_q[j-1];
    end

    always_comb begin
      remx = '0;
      diff = '0;
      for (int l = 0; l < Lanes; l++) begin
        remx = {rem_in[l], low_in[QuoW-1]};
        diff = remx - {1'b0, dvs_in};
        if (remx >= {1'b0, dvs_in}) begin
          rem_d[l] = diff[RemW-1:0];
          quo_d[l] = {quo_in[l][QuoW-2:0], 1'b1};
        end else begin
          rem_d[l] = remx[RemW-1:0];
          quo_d[l] = {quo_in[l][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        dvs_q[j] <= dvs_in;
        low_q[j] <= {low_in[QuoW-2:0], 1'b0};
        sgn_q[j] <= sgn_in;
      end
    end
  end

  assign valid_o = valid_q[DivSteps-1];
  assign quo_o   = quo_q[DivSteps-1];
  assign sgn_o   = sgn_q[DivSteps-1];

endmodule
